// ===== sv/fpcr_pkg.sv =====
// Shared types, constants and helpers for the false-position cubic root finder.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none
package fpcr_pkg;

  localparam int XW = 28;   // Q12.16 bracket and estimate width
  localparam int FW = 48;   // f(x) width, signed
  localparam int UW = 47;   // |f(x)| width
  localparam int WW = 48;   // |f(a)| + |f(b)| width
  localparam int RW = 51;   // long-division remainder width
  localparam int QW = 29;   // step quotient width
  localparam int BW = 5;    // bit index of the 28 multiplier bits
  localparam int VW = 28;   // |b - a| width
  localparam int CW = 30;   // width of a +/- step before clamping

  localparam logic [BW-1:0] DIV_TOP_BIT = BW'(VW - 1);
  localparam logic signed [XW-1:0] XLIM = XW'(67108864);
  localparam logic signed [CW-1:0] XLIM_W = CW'(67108864);
  localparam logic signed [FW-1:0] F_OFFSET = FW'(9 * 65536);

  localparam logic REG_TOLERANCE  = 1'b0;
  localparam logic REG_ITER_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_EXACT  = 2'd0,
    ST_CONV   = 2'd1,
    ST_NOSIGN = 2'd2,
    ST_LIMIT  = 2'd3
  } fpcr_status_t;

  typedef enum logic [1:0] {
    SRC_A = 2'd0,
    SRC_B = 2'd1,
    SRC_C = 2'd2
  } cub_src_t;

  typedef enum logic [3:0] {
    S_IDLE, S_A_GO, S_A_WAIT, S_B_GO, S_B_WAIT, S_CHECK, S_DIV_INIT,
    S_DIV_SHIFT, S_DIV_SUB, S_MAKE_C, S_C_GO, S_C_WAIT, S_UPDATE, S_CONV,
    S_FINISH
  } fpcr_state_t;

  typedef struct packed {
    logic signed [XW-1:0] guess_low;
    logic signed [XW-1:0] guess_high;
  } req_t;

  typedef struct packed {
    logic signed [XW-1:0] root;
    fpcr_status_t         status;
    logic [7:0]           iterations;
  } res_t;

  typedef struct packed {
    logic         load;
    logic         cub_start;
    logic         cub_latch;
    cub_src_t     cub_src;
    logic         div_init;
    logic         div_shift;
    logic         div_sub;
    logic         div_next;
    logic         make_c;
    logic         update;
    logic         out_load;
    fpcr_status_t out_status;
  } ctl_cmd_t;

  typedef struct packed {
    logic cub_done;
    logic bad_interval;
    logic r_ge_w;
    logic bit_last;
    logic fc_zero;
    logic conv;
    logic limit_hit;
    logic out_busy;
  } ctl_sts_t;

  function automatic logic signed [XW-1:0] clampx(input logic signed [CW-1:0] x);
    if (x > XLIM_W) begin
      return XLIM;
    end else if (x < -XLIM_W) begin
      return -XLIM;
    end
    return x[XW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/fpcr_cubic.sv =====
// Pipelined evaluator of f(x) = x^3 - 4x - 9 on a Q12.16 argument.
// Depends on fpcr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fpcr_cubic (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  input  wire logic signed [fpcr_pkg::XW-1:0] x,
  output logic                            done,
  output logic signed [fpcr_pkg::FW-1:0]  f
);
  import fpcr_pkg::*;

  logic                 v1, v2, v3;
  logic [XW-2:0]        ax;
  logic                 neg1, neg2;
  logic signed [XW-1:0] x1, x2;
  logic [2*XW-3:0]      p;
  logic [42:0]          mlo;
  logic [48:0]          mhi;
  logic [XW-1:0]        xabs;
  logic [37:0]          sq;
  logic [UW-1:0]        cube;
  logic signed [FW-1:0] cube_s;

  assign xabs = x[XW-1] ? XW'(-x) : XW'(x);
  assign sq   = p[53:16];
  assign cube = mhi[UW-1:0] + UW'(mlo[42:16]);
  assign cube_s = neg2 ? -FW'(signed'({1'b0, cube})) : FW'(signed'({1'b0, cube}));
  // The final sum is formed from the last product stage, so it is valid with done.
  assign f    = cube_s - (FW'(x2) <<< 2) - F_OFFSET;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ax <= xabs[XW-2:0];
      x1 <= x;
      neg1 <= x[XW-1];
    end
    // The square is split into two partial products against |x|.
    p    <= ax * ax;
    mlo  <= sq[15:0] * ax;
    mhi  <= sq[37:16] * ax;
    x2   <= x1;
    neg2 <= neg1;
  end

  assign done = v3;
endmodule
`default_nettype wire

// ===== sv/fpcr_datapath.sv =====
// Datapath of the root finder: bracket registers, bit-serial step divider, cubic unit,
// convergence test and result register. Depends on fpcr_pkg and fpcr_cubic.
`timescale 1ns / 1ps
`default_nettype none
module fpcr_datapath (
  input  wire                   clk,
  input  wire                   rst,
  input  wire fpcr_pkg::req_t   req_data,
  input  wire logic [15:0]      tolerance,
  input  wire logic [7:0]       iteration_limit,
  input  wire fpcr_pkg::ctl_cmd_t cmd,
  output fpcr_pkg::ctl_sts_t    sts,
  output logic                  res_valid,
  input  wire                   res_stall,
  output fpcr_pkg::res_t        res_data
);
  import fpcr_pkg::*;

  logic signed [XW-1:0] a, b, c;
  logic signed [FW-1:0] fa, fb, fc;
  logic [UW-1:0]        u;
  logic [WW-1:0]        w;
  logic [VW-1:0]        v;
  logic [RW-1:0]        r;
  logic [QW-1:0]        q;
  logic [BW-1:0]        bitn;
  logic [7:0]           iters;

  logic signed [XW-1:0] cub_x;
  logic signed [FW-1:0] cub_f;
  logic                 cub_done;
  logic signed [XW:0]   diff;
  logic [VW-1:0]        absd;
  logic [XW-2:0]        absb;
  logic [XW-1:0]        absb_w;
  logic [UW-1:0]        absfa, absfb;
  logic [43:0]          lhs;
  logic [42:0]          rhs;
  logic [7:0]           lim_eff;
  logic signed [CW-1:0] c_sum;

  always_comb begin
    unique case (cmd.cub_src)
      SRC_A:   cub_x = a;
      SRC_B:   cub_x = b;
      default: cub_x = c;
    endcase
  end

  fpcr_cubic u_cubic (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.cub_start),
    .x     (cub_x),
    .done  (cub_done),
    .f     (cub_f)
  );

  assign diff   = (XW+1)'(b) - (XW+1)'(a);
  assign absd   = diff[XW] ? VW'(-diff) : VW'(diff);
  assign absb_w = b[XW-1] ? XW'(-b) : XW'(b);
  assign absb   = absb_w[XW-2:0];
  assign absfa  = fa[FW-1] ? UW'(-fa) : UW'(fa);
  assign absfb  = fb[FW-1] ? UW'(-fb) : UW'(fb);
  assign lhs    = {absd, 16'b0};
  assign rhs    = tolerance * absb;
  assign lim_eff = (iteration_limit == 8'd0) ? 8'd1 : iteration_limit;
  assign c_sum  = diff[XW] ? CW'(a) - CW'(signed'({1'b0, q}))
                           : CW'(a) + CW'(signed'({1'b0, q}));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a     <= clampx(CW'(req_data.guess_low));
      b     <= clampx(CW'(req_data.guess_high));
      c     <= '0;
      iters <= '0;
    end
    if (cmd.cub_latch) begin
      unique case (cmd.cub_src)
        SRC_A:   fa <= cub_f;
        SRC_B:   fb <= cub_f;
        default: fc <= cub_f;
      endcase
    end
    if (cmd.div_init) begin
      u    <= absfa;
      w    <= WW'(absfa) + WW'(absfb);
      v    <= absd;
      r    <= '0;
      q    <= '0;
      bitn <= DIV_TOP_BIT;
    end
    if (cmd.div_shift) begin
      r <= (r << 1) + (v[bitn] ? RW'(u) : RW'(0));
      q <= q << 1;
    end
    if (cmd.div_sub) begin
      r <= r - RW'(w);
      q <= q + QW'(1);
    end
    if (cmd.div_next) begin
      bitn <= bitn - BW'(1);
    end
    if (cmd.make_c) begin
      c     <= clampx(c_sum);
      iters <= iters + 8'd1;
    end
    if (cmd.update) begin
      if (fc[FW-1] != fa[FW-1]) begin
        b  <= c;
        fb <= fc;
      end else begin
        a  <= c;
        fa <= fc;
      end
    end
    if (cmd.out_load) begin
      res_data.root       <= c;
      res_data.status     <= cmd.out_status;
      res_data.iterations <= iters;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.cub_done     = cub_done;
    sts.bad_interval = (fa == '0) || (fb == '0) || (fa[FW-1] == fb[FW-1]);
    sts.r_ge_w       = r >= RW'(w);
    sts.bit_last     = bitn == '0;
    sts.fc_zero      = fc == '0;
    sts.conv         = lhs <= {1'b0, rhs};
    sts.limit_hit    = iters >= lim_eff;
    sts.out_busy     = res_valid && res_stall;
  end
endmodule
`default_nettype wire

// ===== sv/fpcr_ctrl.sv =====
// Controller state machine: sequences cubic evaluations, the step division and the
// bracket update. Depends on fpcr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fpcr_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     req_valid,
  output logic                    req_stall,
  input  wire fpcr_pkg::ctl_sts_t sts,
  output fpcr_pkg::ctl_cmd_t      cmd
);
  import fpcr_pkg::*;

  fpcr_state_t  state, state_next;
  fpcr_status_t fin, fin_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin   <= ST_EXACT;
    end else begin
      state <= state_next;
      fin   <= fin_next;
    end
  end

  always_comb begin
    state_next = state;
    fin_next   = fin;
    cmd        = '0;
    cmd.cub_src    = SRC_A;
    cmd.out_status = fin;
    req_stall  = state != S_IDLE;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_A_GO;
        end
      end
      S_A_GO: begin
        cmd.cub_start = 1'b1;
        state_next    = S_A_WAIT;
      end
      S_A_WAIT: begin
        if (sts.cub_done) begin
          cmd.cub_latch = 1'b1;
          state_next    = S_B_GO;
        end
      end
      S_B_GO: begin
        cmd.cub_src   = SRC_B;
        cmd.cub_start = 1'b1;
        state_next    = S_B_WAIT;
      end
      S_B_WAIT: begin
        cmd.cub_src = SRC_B;
        if (sts.cub_done) begin
          cmd.cub_latch = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.bad_interval) begin
          fin_next   = ST_NOSIGN;
          state_next = S_FINISH;
        end else begin
          state_next = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV_SHIFT;
      end
      S_DIV_SHIFT: begin
        cmd.div_shift = 1'b1;
        state_next    = S_DIV_SUB;
      end
      S_DIV_SUB: begin
        priority if (sts.r_ge_w) begin
          cmd.div_sub = 1'b1;
        end else if (sts.bit_last) begin
          state_next = S_MAKE_C;
        end else begin
          cmd.div_next = 1'b1;
          state_next   = S_DIV_SHIFT;
        end
      end
      S_MAKE_C: begin
        cmd.make_c = 1'b1;
        state_next = S_C_GO;
      end
      S_C_GO: begin
        cmd.cub_src   = SRC_C;
        cmd.cub_start = 1'b1;
        state_next    = S_C_WAIT;
      end
      S_C_WAIT: begin
        cmd.cub_src = SRC_C;
        if (sts.cub_done) begin
          cmd.cub_latch = 1'b1;
          state_next    = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (sts.fc_zero) begin
          fin_next   = ST_EXACT;
          state_next = S_FINISH;
        end else begin
          cmd.update = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        priority if (sts.conv) begin
          fin_next   = ST_CONV;
          state_next = S_FINISH;
        end else if (sts.limit_hit) begin
          fin_next   = ST_LIMIT;
          state_next = S_FINISH;
        end else begin
          state_next = S_DIV_INIT;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/false_position_cubic_root_top.sv =====
// Top level of the false-position root finder for x^3 - 4x - 9: APB registers,
// controller and datapath. Depends on fpcr_pkg, fpcr_ctrl and fpcr_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Each request carries two Q12.16 bracket ends, which are clamped to a magnitude of
// 1024, and yields one result with the last estimate, a status code and the number of
// iterations. The block works on one request at a time. Both ends are evaluated first;
// each iteration then runs a 28-bit restoring long division (a shift, a compare and up
// to two subtractions for each multiplier bit) followed by a cubic evaluation on the
// three-stage multiplier pipeline and the update and convergence steps. The default
// limit is 64 iterations. A finished result sits in the output register, so the next
// request is taken while it waits. Registers: tolerance at byte address 0,
// iteration_limit at byte address 4; write them only while no request is in flight.
module false_position_cubic_root_top (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   req_valid,
  output logic                  req_stall,
  input  wire fpcr_pkg::req_t   req_data,
  output logic                  res_valid,
  input  wire                   res_stall,
  output fpcr_pkg::res_t        res_data,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import fpcr_pkg::*;

  logic [15:0] tolerance;
  logic [7:0]  iteration_limit;
  ctl_cmd_t    cmd;
  ctl_sts_t    sts;

  // A register write lands in the access phase; pready is tied high.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance       <= 16'd7;
      iteration_limit <= 8'd64;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_TOLERANCE) begin
        tolerance <= pwdata[15:0];
      end else begin
        iteration_limit <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ITER_LIMIT) ? {24'b0, iteration_limit}
                                               : {16'b0, tolerance};

  fpcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpcr_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .req_data        (req_data),
    .tolerance       (tolerance),
    .iteration_limit (iteration_limit),
    .cmd             (cmd),
    .sts             (sts),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .res_data        (res_data)
  );
endmodule
`default_nettype wire

// ===== sv/fpcr_checker.sv =====
// Port-level checker for the root finder, bound to the top level.
// Depends on fpcr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fpcr_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 req_valid,
  input wire                 req_stall,
  input wire fpcr_pkg::req_t req_data,
  input wire                 res_valid,
  input wire                 res_stall,
  input wire fpcr_pkg::res_t res_data
);
  import fpcr_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken while one is in flight");

  a_nosign_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status == ST_NOSIGN |->
      res_data.iterations == 8'd0 && res_data.root == '0)
    else $error("bad interval result carries an estimate");

  a_iter_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status != ST_NOSIGN |-> res_data.iterations != 8'd0)
    else $error("search result without iterations");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");
endmodule

bind false_position_cubic_root_top fpcr_checker u_fpcr_checker (.*);
`default_nettype wire

// ===== bench/false_position_cubic_root_top_tb.sv =====
// Testbench for the false-position cubic root finder: drives bracket requests and APB
// register writes, predicts every result in its own model. Depends on fpcr_pkg and the RTL.
`timescale 1ns / 1ps
module false_position_cubic_root_top_tb;
  import fpcr_pkg::*;

  localparam int LIMIT_CYCLES = 20000000;
  localparam logic [2:0] ADDR_TOL = 3'd0;
  localparam logic [2:0] ADDR_ITER = 3'd4;
  localparam longint BOUND = 64'sd67108864;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req_data;
  logic res_valid;
  logic res_stall;
  res_t res_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  false_position_cubic_root_top u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // The predictor keeps its own copy of both registers.
  logic [15:0] tol_shadow;
  logic [7:0] iter_shadow;
  res_t root_queue[$];
  int mismatches;
  int cycles;
  bit quiet;      // a stretch with no idling on either side
  int res_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[false_position_cubic_root_top] ERROR");
      $finish;
    end
  end

  function automatic longint sat_bracket(longint x);
    if (x > BOUND) return BOUND;
    if (x < -BOUND) return -BOUND;
    return x;
  endfunction

  function automatic longint cubic_q16(longint x);
    longint sq;
    longint cu;
    sq = (x * x) >>> 16;
    cu = (sq * x) / 65536;   // truncates toward zero
    return cu - 4 * x - 9 * 65536;
  endfunction

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  // Exact floor(u*v/w) on 128 bits; the operands stay well below that.
  function automatic longint scaled_step(longint u, longint v, longint w);
    logic [127:0] p;
    p = 128'(u) * 128'(v);
    return longint'(p / 128'(w));
  endfunction

  function automatic res_t solve_root(req_t rq);
    res_t r;
    longint a, b, fa, fb, c, fc, d, st;
    int lim, n;
    a = sat_bracket(longint'(rq.guess_low));
    b = sat_bracket(longint'(rq.guess_high));
    fa = cubic_q16(a);
    fb = cubic_q16(b);
    c = 0;
    n = 0;
    lim = (iter_shadow == 0) ? 1 : int'(iter_shadow);
    if (fa == 0 || fb == 0 || ((fa < 0) == (fb < 0))) begin
      r.status = ST_NOSIGN;
    end else begin
      forever begin
        d = b - a;
        st = scaled_step(mag(fa), mag(d), mag(fa) + mag(fb));
        c = sat_bracket(d < 0 ? a - st : a + st);
        fc = cubic_q16(c);
        n++;
        if (fc == 0) begin
          r.status = ST_EXACT;
          break;
        end
        if ((fc < 0) != (fa < 0)) begin
          b = c;
          fb = fc;
        end else begin
          a = c;
          fa = fc;
        end
        if (mag(b - a) * 65536 <= longint'(tol_shadow) * mag(b)) begin
          r.status = ST_CONV;
          break;
        end
        if (n >= lim) begin
          r.status = ST_LIMIT;
          break;
        end
      end
    end
    r.root = c[XW-1:0];
    r.iterations = n[7:0];
    return r;
  endfunction

  // Result side: random stall, and every accepted result is checked.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_seen <= res_seen + 1;
        if (root_queue.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %h", res_data);
        end else begin
          want = root_queue.pop_front();
          if (res_data.root !== want.root || res_data.status !== want.status ||
              res_data.iterations !== want.iterations) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: want root %h status %0d iter %0d, got %h %0d %0d",
                       want.root, want.status, want.iterations,
                       res_data.root, res_data.status, res_data.iterations);
          end
        end
      end
      res_stall <= quiet ? 1'b0 : ($urandom_range(99) < 11);
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_TOL) tol_shadow = value[15:0];
    else iter_shadow = value[7:0];
    // The bus idles between transfers.
    @(posedge clk);
  endtask

  // Sends one request; the expectation is queued once req_stall is low again.
  // Valid is left high so that the next request can follow at once.
  task automatic send_bracket(input req_t rq, input bit typed, input res_t typed_res);
    while (!quiet && $urandom_range(99) < 11) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= rq;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    root_queue.push_back(typed ? typed_res : solve_root(rq));
  endtask

  // Waits for every pending result, then for the block to settle.
  task automatic drain;
    req_valid <= 1'b0;
    while (root_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic req_t mk(longint lo, longint hi);
    req_t r;
    r.guess_low = lo[XW-1:0];
    r.guess_high = hi[XW-1:0];
    return r;
  endfunction

  // Directed rows: bracket ends and whether the row is checked against a typed
  // result (no sign change gives all zeros) instead of the model.
  typedef struct {
    longint lo;
    longint hi;
    bit typed;
  } row_t;

  row_t rows[16];

  initial begin
    res_t zero_nosign;
    res_t dummy;
    req_t rq;
    longint lo, hi;
    int sel;
    cycles = 0;
    mismatches = 0;
    res_seen = 0;
    quiet = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tol_shadow = 16'd7;
    iter_shadow = 8'd64;
    zero_nosign.root = '0;
    zero_nosign.status = ST_NOSIGN;
    zero_nosign.iterations = '0;
    dummy = zero_nosign;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Classic bracket around the root near 2.7065, both orders, wide extremes,
    // out-of-range guesses that saturate, no sign change, and a zero end.
    rows[0] = '{2 * 65536, 3 * 65536, 1'b0};
    rows[1] = '{3 * 65536, 2 * 65536, 1'b0};
    rows[2] = '{-BOUND, BOUND, 1'b0};
    rows[3] = '{BOUND, -BOUND, 1'b0};
    rows[4] = '{-134217728, 134217727, 1'b0};   // field extremes, saturated
    rows[5] = '{0, 0, 1'b1};                     // f(0) < 0 on both ends
    rows[6] = '{3 * 65536, 4 * 65536, 1'b1};     // both positive
    rows[7] = '{-BOUND, -BOUND, 1'b1};
    rows[8] = '{0, 5 * 65536, 1'b0};             // convergence tested against b
    rows[9] = '{5 * 65536, 0, 1'b0};             // b = 0 end
    rows[10] = '{2 * 65536, 2 * 65536 + 1, 1'b1}; // no change in sign
    rows[11] = '{2 * 65536 + 46000, 2 * 65536 + 46500, 1'b0};
    rows[12] = '{-1, 134217727, 1'b0};
    rows[13] = '{1, 2, 1'b1};
    rows[14] = '{177360, 177380, 1'b0};          // tight bracket, tiny steps
    rows[15] = '{-5 * 65536, 10 * 65536, 1'b0};
    foreach (rows[i]) send_bracket(mk(rows[i].lo, rows[i].hi), rows[i].typed, zero_nosign);
    drain();

    // Register extremes: zero limit acts as one, zero tolerance, widest tolerance.
    reg_write(ADDR_ITER, 32'd0);
    reg_write(ADDR_TOL, 32'd0);
    send_bracket(mk(2 * 65536, 3 * 65536), 1'b0, dummy);
    send_bracket(mk(-BOUND, BOUND), 1'b0, dummy);
    drain();
    reg_write(ADDR_ITER, 32'd255);
    reg_write(ADDR_TOL, 32'hFFFF_FFFF);          // only the low 16 bits stick
    send_bracket(mk(2 * 65536, 3 * 65536), 1'b0, dummy);
    send_bracket(mk(BOUND, -BOUND), 1'b0, dummy);
    drain();
    reg_write(ADDR_TOL, 32'd0);
    send_bracket(mk(-BOUND, BOUND), 1'b0, dummy);
    drain();

    // Random part in phases with different settings; most brackets straddle
    // the root so the iteration actually runs.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          reg_write(ADDR_TOL, 32'd7);
          reg_write(ADDR_ITER, 32'd64);
        end
        1: begin
          reg_write(ADDR_TOL, $urandom_range(65535));
          reg_write(ADDR_ITER, $urandom_range(1, 16));
        end
        2: begin
          reg_write(ADDR_TOL, $urandom_range(200));
          reg_write(ADDR_ITER, 32'd1);
        end
        default: begin
          reg_write(ADDR_TOL, 32'd1);
          reg_write(ADDR_ITER, $urandom_range(32, 255));
        end
      endcase
      quiet = (ph == 0);
      for (int k = 0; k < 55; k++) begin
        sel = $urandom_range(9);
        if (sel < 7) begin
          lo = -longint'($urandom_range(67108864)) + 177000;
          hi = longint'($urandom_range(67108864 - 178000)) + 178000;
          if (sel < 3) begin
            lo = 177000 - longint'($urandom_range(200000));
            hi = 178000 + longint'($urandom_range(200000));
          end
          if ($urandom_range(1)) begin
            rq = mk(hi, lo);
          end else begin
            rq = mk(lo, hi);
          end
        end else begin
          rq.guess_low = XW'($urandom());
          rq.guess_high = XW'($urandom());
        end
        send_bracket(rq, 1'b0, dummy);
      end
      drain();
    end

    quiet = 1'b0;
    drain();
    if (mismatches == 0 && root_queue.size() == 0) begin
      $display("[false_position_cubic_root_top] OK");
    end else begin
      $display("[false_position_cubic_root_top] ERROR");
    end
    $finish;
  end

endmodule
